// ===== rtl/morph_priority_vertex_blender_macros.svh =====
// Assertion macros shared by the morph priority vertex blender RTL.
`ifndef MORPH_PRIORITY_VERTEX_BLENDER_MACROS_SVH
`define MORPH_PRIORITY_VERTEX_BLENDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPVB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPVB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mpvb_pkg.sv =====
// Shared types and constants of the morph priority vertex blender.
`default_nettype none

package mpvb_pkg;

   localparam int unsigned CMD_BITS    = 2;
   localparam int unsigned VINDEX_BITS = 12;
   localparam int unsigned LIP_BITS    = 23;
   localparam int unsigned ACC_BITS    = 32;

   typedef logic [CMD_BITS-1:0] cmd_type;

   localparam cmd_type CMD_LOAD  = 2'd0;
   localparam cmd_type CMD_ACCUM = 2'd1;
   localparam cmd_type CMD_BLEND = 2'd2;
   localparam cmd_type CMD_NONE  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/mpvb_req_if.sv =====
// Request channel interface of the morph priority vertex blender.
`default_nettype none

interface mpvb_req_if #(
   parameter int unsigned COORD_BITS = 24
);
   logic                                valid;
   logic                                ready;
   mpvb_pkg::cmd_type                   cmd;
   logic [mpvb_pkg::VINDEX_BITS-1:0]    vertex_index;
   logic signed [COORD_BITS-1:0]        in_x;
   logic signed [COORD_BITS-1:0]        in_y;
   logic signed [COORD_BITS-1:0]        in_z;
   logic signed [COORD_BITS-1:0]        cur_x;
   logic signed [COORD_BITS-1:0]        cur_y;
   logic signed [COORD_BITS-1:0]        cur_z;
   logic                                in_lip_area;
   logic                                lip_area_known;

   modport source (
      output valid, cmd, vertex_index, in_x, in_y, in_z, cur_x, cur_y, cur_z,
             in_lip_area, lip_area_known,
      input  ready
   );

   modport sink (
      input  valid, cmd, vertex_index, in_x, in_y, in_z, cur_x, cur_y, cur_z,
             in_lip_area, lip_area_known,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/mpvb_rsp_if.sv =====
// Response channel interface of the morph priority vertex blender.
`default_nettype none

interface mpvb_rsp_if #(
   parameter int unsigned COORD_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;

   modport source (
      output valid, out_x, out_y, out_z,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/mpvb_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module mpvb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/morph_priority_vertex_blender.sv =====
// Top level of the morph priority vertex blender.
// The request channel carries one command beat: load a rest vertex, accumulate
// an expression vertex, or blend a current vertex with an expression vertex.
// Only a blend beat produces a response beat, which carries the blended vertex.
// The user must write the lip threshold register through csr_we and csr_wdata
// only while idle; the block itself does not enforce this. Rest vertices live in
// one RAM and the three difference accumulators in another, each a synchronous
// RAM with a registered read port, and each command is done with its entry before
// the next beat enters: a load writes the rest vertex and clears the accumulators,
// an accumulate reads, adds and writes back, and a blend only reads. Every beat
// passes the quotient and modulo steps of the index reduction and the RAM read
// step; an accumulate then takes the calc and update steps, and a blend the calc
// step, the multiply-by-reciprocal divide by ten, its correction and the output
// step. The response sits in an output register; a new request is accepted while
// it waits, and only a later blend stalls in its last step until the register
// frees. Synchronous reset clears the control state, the maxima and the threshold;
// the RAM contents are not cleared and there is no clearing pass.
`default_nettype none
`include "morph_priority_vertex_blender_macros.svh"

module morph_priority_vertex_blender #(
   parameter int unsigned VERTICES   = 4096,
   parameter int unsigned COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   mpvb_req_if.sink                          req_if,
   mpvb_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [mpvb_pkg::LIP_BITS-1:0]     csr_wdata
);

   localparam int unsigned CB       = COORD_BITS;
   localparam int unsigned VB       = mpvb_pkg::VINDEX_BITS;
   localparam int unsigned AB       = mpvb_pkg::ACC_BITS;
   localparam int unsigned IDX_BITS = $clog2(VERTICES);
   localparam int unsigned RSH      = 2 * VB;
   localparam int unsigned NW       = CB + 5;
   localparam int unsigned NM       = CB + 4;
   localparam int unsigned QW       = CB + 1;
   localparam int unsigned TW       = AB + 1;
   localparam int unsigned DW       = AB + 5;

   localparam logic [VB:0]  VLIM  = (VERTICES > (1 << VB)) ? (VB+1)'(1 << VB)
                                                            : (VB+1)'(VERTICES);
   localparam logic [RSH-1:0] RECIP = RSH'((64'd1 << RSH) / VERTICES);
   localparam logic [QW-1:0]  R10   = QW'((64'd1 << NM) / 64'd10);

   localparam logic signed [NW-1:0] K10  = NW'(64'd10 << CB);
   localparam logic signed [NW-1:0] K1   = NW'(64'd1 << CB);
   localparam logic signed [NW-1:0] SMAX = NW'((64'd1 << (CB - 1)) - 64'd1);
   localparam logic signed [NW-1:0] SMIN = -SMAX - NW'(1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_QUOT = 4'd1;
   localparam logic [3:0] ST_MOD  = 4'd2;
   localparam logic [3:0] ST_READ = 4'd3;
   localparam logic [3:0] ST_CALC = 4'd4;
   localparam logic [3:0] ST_UPD  = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_FIX  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   function automatic logic [CB-1:0] abs_diff(input logic signed [CB-1:0] a,
                                              input logic signed [CB-1:0] b);
      logic signed [CB:0] d;
      d = (CB+1)'(a) - (CB+1)'(b);
      if (d < 0) begin
         d = -d;
      end
      return d[CB-1:0];
   endfunction

   function automatic logic [AB-1:0] sat_add(input logic [AB-1:0] a,
                                             input logic [CB-1:0] d);
      logic [AB:0] s;
      s = {1'b0, a} + (AB+1)'(d);
      return s[AB] ? {AB{1'b1}} : s[AB-1:0];
   endfunction

   function automatic logic signed [CB-1:0] sat_coord(input logic signed [NW-1:0] v);
      logic signed [NW-1:0] c;
      c = v;
      if (v > SMAX) begin
         c = SMAX;
      end else if (v < SMIN) begin
         c = SMIN;
      end
      return c[CB-1:0];
   endfunction

   // Control state.
   logic [3:0]             state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]          max_x_ff, max_y_ff, max_z_ff;
   logic [AB-1:0]          max_x_in, max_y_in, max_z_in;
   logic [mpvb_pkg::LIP_BITS-1:0] lip_thr_ff, lip_thr_in;

   // Captured request beat.
   mpvb_pkg::cmd_type      cmd_ff;
   logic [VB-1:0]          vi_ff;
   logic signed [CB-1:0]   ex_ff, ey_ff, ez_ff, cx_ff, cy_ff, cz_ff;
   logic                   lip_ff, known_ff;

   // Datapath registers.
   logic [VB-1:0]          q_ff, q_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [CB-1:0]          diff_x_ff, diff_y_ff, diff_z_ff;
   logic [CB-1:0]          diff_x_in, diff_y_in, diff_z_in;
   logic                   dx_ff, dy_ff, dz_ff, far_ff;
   logic                   dx_in, dy_in, dz_in, far_in;
   logic signed [NW-1:0]   nx_ff, nz_ff, ny3_ff;
   logic signed [NW-1:0]   nx_in, nz_in, ny3_in;
   logic [NM-1:0]          m_ff, m_in;
   logic [QW-1:0]          qe_ff, qe_in;
   logic [QW-1:0]          y7q_ff, y7q_in;
   logic signed [CB-1:0]   out_x_ff, out_y_ff, out_z_ff;
   logic signed [CB-1:0]   out_x_in, out_y_in, out_z_in;

   // Combinational helpers.
   logic                   accept;
   logic                   out_load;
   logic [VB+RSH-1:0]      recip_prod_w;
   logic [2*VB:0]          qv_w;
   logic [VB-1:0]          rem_w, rem_fix_w;
   logic [NM+QW-1:0]       div_prod_w;
   logic [NM:0]            q10_w, r10_w;
   logic signed [NW-1:0]   ex_w, ey_w, ez_w, cx_w, cy_w, cz_w;
   logic signed [NW-1:0]   ny7_w, y7_w, ox_w, oy_w, oz_w;
   logic [DW-1:0]          ay20_w;
   logic signed [CB-1:0]   rx_w, ry_w, rz_w;
   logic [AB-1:0]          ax_w, ay_w, az_w;
   logic [AB-1:0]          acc_new_x_w, acc_new_y_w, acc_new_z_w;

   // RAM ports.
   logic                   rest_we, rest_re, acc_we;
   logic [3*CB-1:0]        rest_wdata, rest_rdata;
   logic [3*AB-1:0]        acc_wdata, acc_rdata;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);

   // Index reduction modulo the vertex count.
   assign recip_prod_w = (VB+RSH)'(vi_ff) * (VB+RSH)'(RECIP);
   assign q_in         = recip_prod_w[RSH +: VB];
   assign qv_w         = (2*VB+1)'(q_ff) * (2*VB+1)'(VLIM);
   assign rem_w        = vi_ff - qv_w[VB-1:0];
   assign rem_fix_w    = ({1'b0, rem_w} >= VLIM) ? (rem_w - VLIM[VB-1:0]) : rem_w;
   assign idx_in       = IDX_BITS'(rem_fix_w);

   // RAM read data.
   assign rx_w = rest_rdata[2*CB +: CB];
   assign ry_w = rest_rdata[CB +: CB];
   assign rz_w = rest_rdata[0 +: CB];
   assign ax_w = acc_rdata[2*AB +: AB];
   assign ay_w = acc_rdata[AB +: AB];
   assign az_w = acc_rdata[0 +: AB];

   assign ex_w = NW'(ex_ff);
   assign ey_w = NW'(ey_ff);
   assign ez_w = NW'(ez_ff);
   assign cx_w = NW'(cx_ff);
   assign cy_w = NW'(cy_ff);
   assign cz_w = NW'(cz_ff);

   // Accumulate step.
   assign diff_x_in   = abs_diff(ex_ff, rx_w);
   assign diff_y_in   = abs_diff(ey_ff, ry_w);
   assign diff_z_in   = abs_diff(ez_ff, rz_w);
   assign acc_new_x_w = sat_add(ax_w, diff_x_ff);
   assign acc_new_y_w = sat_add(ay_w, diff_y_ff);
   assign acc_new_z_w = sat_add(az_w, diff_z_ff);

   // Blend step: dominance tests and numerators.
   assign ay20_w = DW'({ay_w, 4'b0000}) + DW'({ay_w, 2'b00});
   assign dx_in  = {ax_w, 2'b00} > {2'b00, max_x_ff};
   assign dy_in  = ay20_w > DW'(max_y_ff);
   assign dz_in  = {az_w, 2'b00} > {2'b00, max_z_ff};
   assign far_in = TW'(abs_diff(ry_w, cy_ff)) > TW'(lip_thr_ff);
   assign nx_in  = cx_w + ex_w + (ex_w <<< 1) + NW'(2);
   assign nz_in  = cz_w + ez_w + NW'(1);
   assign ny3_in = cy_w + (cy_w <<< 1) + ey_w + NW'(2);
   assign ny7_w  = (cy_w <<< 3) - cy_w + ey_w + (ey_w <<< 1) + NW'(5) + K10;
   assign m_in   = ny7_w[NM-1:0];

   // Divide by ten: reciprocal estimate, then one correction.
   assign div_prod_w = (NM+QW)'(m_ff) * (NM+QW)'(R10);
   assign qe_in      = div_prod_w[NM +: QW];
   assign q10_w      = (NM+1)'({qe_ff, 3'b000}) + (NM+1)'({qe_ff, 1'b0});
   assign r10_w      = (NM+1)'(m_ff) - q10_w;
   assign y7q_in     = (r10_w >= (NM+1)'(10)) ? (qe_ff + QW'(1)) : qe_ff;

   // Output selection.
   assign y7_w = $signed(NW'(y7q_ff)) - K1;
   assign ox_w = dx_ff ? (nx_ff >>> 2) : ex_w;
   assign oz_w = dz_ff ? (nz_ff >>> 1) : ez_w;

   always_comb begin
      if (!dy_ff) begin
         oy_w = ey_w;
      end else if (!known_ff) begin
         oy_w = cy_w;
      end else if (!lip_ff) begin
         oy_w = ny3_ff >>> 2;
      end else if (far_ff) begin
         oy_w = y7_w;
      end else begin
         oy_w = cy_w;
      end
   end

   assign out_x_in = sat_coord(ox_w);
   assign out_y_in = sat_coord(oy_w);
   assign out_z_in = sat_coord(oz_w);

   // RAM control.
   assign rest_we    = (state_ff == ST_READ) && (cmd_ff == mpvb_pkg::CMD_LOAD);
   assign rest_wdata = {ex_ff, ey_ff, ez_ff};
   assign rest_re    = (state_ff == ST_READ) &&
                       ((cmd_ff == mpvb_pkg::CMD_ACCUM) || (cmd_ff == mpvb_pkg::CMD_BLEND));
   assign acc_we     = rest_we || (state_ff == ST_UPD);
   assign acc_wdata  = (state_ff == ST_UPD) ? {acc_new_x_w, acc_new_y_w, acc_new_z_w}
                                            : '0;

   mpvb_ram #(
      .WIDTH (3 * CB),
      .DEPTH (VERTICES)
   ) u_rest_ram (
      .clock (clock),
      .we    (rest_we),
      .waddr (idx_ff),
      .wdata (rest_wdata),
      .re    (rest_re),
      .raddr (idx_ff),
      .rdata (rest_rdata)
   );

   mpvb_ram #(
      .WIDTH (3 * AB),
      .DEPTH (VERTICES)
   ) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (idx_ff),
      .wdata (acc_wdata),
      .re    (rest_re),
      .raddr (idx_ff),
      .rdata (acc_rdata)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: state_in = ST_MOD;
         ST_MOD:  state_in = ST_READ;
         ST_READ: begin
            case (cmd_ff) inside
               mpvb_pkg::CMD_ACCUM, mpvb_pkg::CMD_BLEND: state_in = ST_CALC;
               default:                                  state_in = ST_IDLE;
            endcase
         end
         ST_CALC: begin
            state_in = (cmd_ff == mpvb_pkg::CMD_ACCUM) ? ST_UPD : ST_DIV;
         end
         ST_UPD:  state_in = ST_IDLE;
         ST_DIV:  state_in = ST_FIX;
         ST_FIX:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      max_z_in = max_z_ff;
      if (rest_we && (idx_ff == '0)) begin
         max_x_in = '0;
         max_y_in = '0;
         max_z_in = '0;
      end else if (state_ff == ST_UPD) begin
         if (acc_new_x_w > max_x_ff) begin
            max_x_in = acc_new_x_w;
         end
         if (acc_new_y_w > max_y_ff) begin
            max_y_in = acc_new_y_w;
         end
         if (acc_new_z_w > max_z_ff) begin
            max_z_in = acc_new_z_w;
         end
      end
   end

   assign lip_thr_in = csr_we ? csr_wdata : lip_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_x_ff     <= '0;
         max_y_ff     <= '0;
         max_z_ff     <= '0;
         lip_thr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         max_z_ff     <= max_z_in;
         lip_thr_ff   <= lip_thr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_if.cmd;
         vi_ff    <= req_if.vertex_index;
         ex_ff    <= req_if.in_x;
         ey_ff    <= req_if.in_y;
         ez_ff    <= req_if.in_z;
         cx_ff    <= req_if.cur_x;
         cy_ff    <= req_if.cur_y;
         cz_ff    <= req_if.cur_z;
         lip_ff   <= req_if.in_lip_area;
         known_ff <= req_if.lip_area_known;
      end
      if (state_ff == ST_QUOT) begin
         q_ff <= q_in;
      end
      if (state_ff == ST_MOD) begin
         idx_ff <= idx_in;
      end
      if (state_ff == ST_CALC) begin
         diff_x_ff <= diff_x_in;
         diff_y_ff <= diff_y_in;
         diff_z_ff <= diff_z_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         dz_ff     <= dz_in;
         far_ff    <= far_in;
         nx_ff     <= nx_in;
         nz_ff     <= nz_in;
         ny3_ff    <= ny3_in;
         m_ff      <= m_in;
      end
      if (state_ff == ST_DIV) begin
         qe_ff <= qe_in;
      end
      if (state_ff == ST_FIX) begin
         y7q_ff <= y7q_in;
      end
      if (out_load) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_x = out_x_ff;
   assign rsp_if.out_y = out_y_ff;
   assign rsp_if.out_z = out_z_ff;

   `MPVB_ASSERT_NXT(a_accept_starts, clock, reset, req_if.valid && req_if.ready, state_ff == ST_QUOT, "accepted beat did not start index reduction")
   `MPVB_ASSERT_IMP(a_idx_range, clock, reset, state_ff == ST_READ, 32'(idx_ff) < VERTICES, "reduced vertex index out of range")
   `MPVB_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT, "response raised outside the output step")
   `MPVB_ASSERT_NXT(a_max_covers, clock, reset, state_ff == ST_UPD, (max_x_ff >= $past(acc_new_x_w)) && (max_y_ff >= $past(acc_new_y_w)) && (max_z_ff >= $past(acc_new_z_w)), "maximum below an updated accumulator")

endmodule

`default_nettype wire

// ===== tb/morph_priority_vertex_blender_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each blended vertex and compares it with the response beats.
module morph_priority_vertex_blender_checker
   import mpvb_pkg::*;
#(
   parameter int unsigned VERTICES   = 4096,
   parameter int unsigned COORD_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   mpvb_req_if                 req,
   mpvb_rsp_if                 rsp,
   input  logic                csr_we,
   input  logic [LIP_BITS-1:0] csr_wdata,
   output int unsigned         error_count,
   output int unsigned         blends_outstanding
);

   localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam longint ACC_LIMIT = longint'(64'hFFFF_FFFF);

   typedef logic signed [COORD_BITS-1:0] coord_t;
   typedef logic [ACC_BITS-1:0] acc_t;
   typedef struct {
      coord_t x;
      coord_t y;
      coord_t z;
   } vertex_t;

   vertex_t             rest_mem[VERTICES];
   acc_t                acc_x_mem[VERTICES];
   acc_t                acc_y_mem[VERTICES];
   acc_t                acc_z_mem[VERTICES];
   acc_t                peak_x;
   acc_t                peak_y;
   acc_t                peak_z;
   logic [LIP_BITS-1:0] lip_limit;
   vertex_t             expected_blends[$];

   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if (num % den != 0 && num < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint abs_diff(longint a, longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic coord_t clamp_coord(longint v);
      if (v > COORD_MAX) begin
         return coord_t'(COORD_MAX);
      end
      if (v < COORD_MIN) begin
         return coord_t'(COORD_MIN);
      end
      return coord_t'(v);
   endfunction

   function automatic acc_t add_distance(acc_t acc, coord_t e, coord_t r);
      longint sum;
      sum = longint'(acc) + abs_diff(longint'(e), longint'(r));
      if (sum > ACC_LIMIT) begin
         sum = ACC_LIMIT;
      end
      return acc_t'(sum);
   endfunction

   function automatic vertex_t predict_blend(vertex_t e, vertex_t c, int unsigned v,
                                             logic in_lip, logic lip_known);
      vertex_t o;
      logic    dom_x;
      logic    dom_y;
      logic    dom_z;
      longint  cy;
      longint  ey;
      dom_x = longint'(acc_x_mem[v]) * 4 > longint'(peak_x);
      dom_y = longint'(acc_y_mem[v]) * 20 > longint'(peak_y);
      dom_z = longint'(acc_z_mem[v]) * 4 > longint'(peak_z);
      cy = longint'(c.y);
      ey = longint'(e.y);
      o.x = dom_x ? clamp_coord(floor_div(longint'(c.x) + 3 * longint'(e.x) + 2, 4)) : e.x;
      o.z = dom_z ? clamp_coord(floor_div(longint'(c.z) + longint'(e.z) + 1, 2)) : e.z;
      if (!dom_y) begin
         o.y = e.y;
      end else if (!lip_known) begin
         o.y = c.y;
      end else if (!in_lip) begin
         o.y = clamp_coord(floor_div(3 * cy + ey + 2, 4));
      end else if (abs_diff(longint'(rest_mem[v].y), cy) > longint'(lip_limit)) begin
         o.y = clamp_coord(floor_div(7 * cy + 3 * ey + 5, 10));
      end else begin
         o.y = c.y;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t checker: %s", $time, what);
      error_count = error_count + 1;
   endtask

   task automatic check_coord(input string name, input coord_t got, input coord_t want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      vertex_t     e;
      vertex_t     c;
      vertex_t     want;
      int unsigned v;
      if (reset) begin
         peak_x = '0;
         peak_y = '0;
         peak_z = '0;
         lip_limit = '0;
         expected_blends.delete();
         error_count = 0;
      end else begin
         if (csr_we) begin
            lip_limit = csr_wdata;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_blends.size() == 0) begin
               report_mismatch("response beat with no blend outstanding");
            end else begin
               want = expected_blends.pop_front();
               check_coord("out_x", rsp.out_x, want.x);
               check_coord("out_y", rsp.out_y, want.y);
               check_coord("out_z", rsp.out_z, want.z);
            end
         end
         if (req.valid && req.ready) begin
            v = req.vertex_index % VERTICES;
            e.x = req.in_x;
            e.y = req.in_y;
            e.z = req.in_z;
            c.x = req.cur_x;
            c.y = req.cur_y;
            c.z = req.cur_z;
            case (req.cmd)
               CMD_LOAD: begin
                  rest_mem[v] = e;
                  acc_x_mem[v] = '0;
                  acc_y_mem[v] = '0;
                  acc_z_mem[v] = '0;
                  if (v == 0) begin
                     peak_x = '0;
                     peak_y = '0;
                     peak_z = '0;
                  end
               end
               CMD_ACCUM: begin
                  acc_x_mem[v] = add_distance(acc_x_mem[v], e.x, rest_mem[v].x);
                  acc_y_mem[v] = add_distance(acc_y_mem[v], e.y, rest_mem[v].y);
                  acc_z_mem[v] = add_distance(acc_z_mem[v], e.z, rest_mem[v].z);
                  if (acc_x_mem[v] > peak_x) peak_x = acc_x_mem[v];
                  if (acc_y_mem[v] > peak_y) peak_y = acc_y_mem[v];
                  if (acc_z_mem[v] > peak_z) peak_z = acc_z_mem[v];
               end
               CMD_BLEND: begin
                  expected_blends.insert(expected_blends.size(),
                     predict_blend(e, c, v, req.in_lip_area, req.lip_area_known));
               end
               default: begin
               end
            endcase
         end
      end
      blends_outstanding = expected_blends.size();
   end

endmodule

// ===== tb/morph_priority_vertex_blender_tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, stimulus, lip threshold writes and the verdict.
module morph_priority_vertex_blender_tb;
   import mpvb_pkg::*;

   localparam int unsigned VERTICES        = 4096;
   localparam int unsigned COORD_BITS      = 24;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 325;
   localparam int unsigned SATURATING_ADDS = 258;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   localparam coord_t COORD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_t COORD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct {
      cmd_type                cmd;
      logic [VINDEX_BITS-1:0] index;
      coord_t                 ex;
      coord_t                 ey;
      coord_t                 ez;
      coord_t                 cx;
      coord_t                 cy;
      coord_t                 cz;
      logic                   in_lip;
      logic                   lip_known;
   } vertex_cmd_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we;
   logic [LIP_BITS-1:0] csr_wdata;
   int unsigned         error_count;
   int unsigned         blends_outstanding;
   int unsigned         cycle_count = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         sent_items = 0;
   bit                  vertex_loaded[VERTICES];
   int unsigned         loaded_list[$];

   mpvb_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   mpvb_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   morph_priority_vertex_blender #(
      .VERTICES   (VERTICES),
      .COORD_BITS (COORD_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   morph_priority_vertex_blender_checker #(
      .VERTICES   (VERTICES),
      .COORD_BITS (COORD_BITS)
   ) blend_check (
      .clock              (clock),
      .reset              (reset),
      .req                (req_if),
      .rsp                (rsp_if),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .error_count        (error_count),
      .blends_outstanding (blends_outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   function automatic coord_t any_coord();
      case ($urandom_range(5, 0))
         0: return COORD_HI;
         1: return COORD_LO;
         2: return '0;
         3: return coord_t'(int'($urandom_range(511, 0)) - 256);
         default: return coord_t'($urandom);
      endcase
   endfunction

   function automatic coord_t near_coord(coord_t base);
      case ($urandom_range(3, 0))
         0: return coord_t'(int'(base) + int'($urandom_range(510, 0)) - 255);
         1: return coord_t'(int'(base) + int'($urandom_range(131070, 0)) - 65535);
         2: return base;
         default: return any_coord();
      endcase
   endfunction

   function automatic vertex_cmd_t make_cmd(cmd_type cmd, int unsigned index);
      vertex_cmd_t b;
      b.cmd = cmd;
      b.index = VINDEX_BITS'(index);
      b.ex = any_coord();
      b.ey = any_coord();
      b.ez = any_coord();
      b.cx = any_coord();
      b.cy = any_coord();
      b.cz = any_coord();
      b.in_lip = 1'($urandom_range(1, 0));
      b.lip_known = 1'($urandom_range(1, 0));
      return b;
   endfunction

   task automatic send_item(input vertex_cmd_t b);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= b.cmd;
      req_if.vertex_index <= b.index;
      req_if.in_x <= b.ex;
      req_if.in_y <= b.ey;
      req_if.in_z <= b.ez;
      req_if.cur_x <= b.cx;
      req_if.cur_y <= b.cy;
      req_if.cur_z <= b.cz;
      req_if.in_lip_area <= b.in_lip;
      req_if.lip_area_known <= b.lip_known;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      if (b.cmd == CMD_LOAD && !vertex_loaded[b.index]) begin
         vertex_loaded[b.index] = 1'b1;
         loaded_list.insert(loaded_list.size(), b.index);
      end
      if (b.cmd != CMD_NONE) begin
         sent_items++;
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (blends_outstanding != 0) @(negedge clock);
   endtask

   task automatic write_lip_limit(input logic [LIP_BITS-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic directed_items();
      vertex_cmd_t b;
      b = make_cmd(CMD_LOAD, 0);
      b.ex = '0; b.ey = '0; b.ez = '0;
      send_item(b);
      b = make_cmd(CMD_LOAD, VERTICES - 1);
      b.ex = COORD_HI; b.ey = COORD_LO; b.ez = COORD_HI;
      send_item(b);
      b = make_cmd(CMD_ACCUM, VERTICES - 1);
      b.ex = COORD_LO; b.ey = COORD_HI; b.ez = COORD_LO;
      send_item(b);
      b = make_cmd(CMD_ACCUM, 0);
      b.ex = 1; b.ey = -1; b.ez = 1;
      send_item(b);
      b = make_cmd(CMD_BLEND, 0);
      b.ex = COORD_HI; b.ey = COORD_LO; b.ez = COORD_HI;
      b.cx = COORD_LO; b.cy = COORD_HI; b.cz = COORD_LO;
      send_item(b);
      b = make_cmd(CMD_BLEND, VERTICES - 1);
      b.ex = COORD_HI; b.ey = COORD_HI; b.ez = COORD_HI;
      b.cx = COORD_HI; b.cy = COORD_LO; b.cz = COORD_HI;
      b.lip_known = 1'b0;
      send_item(b);
      b = make_cmd(CMD_BLEND, VERTICES - 1);
      b.ex = COORD_LO; b.ey = COORD_LO; b.ez = COORD_LO;
      b.cx = COORD_LO; b.cy = COORD_LO; b.cz = COORD_LO;
      b.lip_known = 1'b1; b.in_lip = 1'b0;
      send_item(b);
      b = make_cmd(CMD_BLEND, VERTICES - 1);
      b.ey = COORD_LO; b.cy = COORD_HI;
      b.lip_known = 1'b1; b.in_lip = 1'b1;
      send_item(b);
      b = make_cmd(CMD_BLEND, VERTICES - 1);
      b.ey = COORD_HI; b.cy = COORD_LO;
      b.lip_known = 1'b1; b.in_lip = 1'b1;
      send_item(b);
      b = make_cmd(CMD_BLEND, VERTICES - 1);
      b.ey = COORD_LO; b.cy = COORD_LO + 1;
      b.lip_known = 1'b1; b.in_lip = 1'b1;
      send_item(b);
      send_item(make_cmd(CMD_NONE, VERTICES - 1));
      send_item(make_cmd(CMD_NONE, 0));
      b = make_cmd(CMD_LOAD, 0);
      b.ex = '0; b.ey = '0; b.ez = '0;
      send_item(b);
      b = make_cmd(CMD_BLEND, VERTICES - 1);
      b.lip_known = 1'b1; b.in_lip = 1'b0;
      send_item(b);
      send_item(make_cmd(CMD_BLEND, 0));
      b = make_cmd(CMD_ACCUM, 0);
      b.ex = COORD_HI; b.ey = COORD_HI; b.ez = COORD_HI;
      send_item(b);
      b = make_cmd(CMD_BLEND, 0);
      b.lip_known = 1'b1; b.in_lip = 1'b1;
      send_item(b);
   endtask

   task automatic saturate_vertex(input int unsigned index);
      vertex_cmd_t b;
      b = make_cmd(CMD_LOAD, index);
      b.ex = COORD_LO; b.ey = COORD_LO; b.ez = COORD_HI;
      send_item(b);
      repeat (SATURATING_ADDS) begin
         b = make_cmd(CMD_ACCUM, index);
         b.ex = COORD_HI; b.ey = COORD_HI; b.ez = COORD_LO;
         send_item(b);
      end
      send_item(make_cmd(CMD_BLEND, index));
   endtask

   task automatic mesh_sequence();
      int unsigned count;
      int unsigned rounds;
      int unsigned slot[6];
      coord_t      base_x[6];
      coord_t      base_y[6];
      coord_t      base_z[6];
      vertex_cmd_t b;
      count = $urandom_range(6, 1);
      rounds = $urandom_range(4, 1);
      for (int k = 0; k < count; k++) begin
         if (k == 0 && $urandom_range(3, 0) == 0) begin
            slot[k] = 0;
         end else if ($urandom_range(7, 0) == 0) begin
            slot[k] = $urandom_range(VERTICES - 1, 0);
         end else begin
            slot[k] = $urandom_range(31, 0);
         end
         b = make_cmd(CMD_LOAD, slot[k]);
         base_x[k] = b.ex;
         base_y[k] = b.ey;
         base_z[k] = b.ez;
         send_item(b);
      end
      for (int r = 0; r < rounds; r++) begin
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(9, 0) < 6) begin
               b = make_cmd(CMD_ACCUM, slot[k]);
               b.ex = near_coord(base_x[k]);
               b.ey = near_coord(base_y[k]);
               b.ez = near_coord(base_z[k]);
               send_item(b);
            end
         end
      end
      for (int k = 0; k < count; k++) begin
         b = make_cmd(CMD_BLEND, slot[k]);
         b.ex = near_coord(base_x[k]);
         b.ey = near_coord(base_y[k]);
         b.ez = near_coord(base_z[k]);
         if ($urandom_range(1, 0) == 1) begin
            b.cy = near_coord(base_y[k]);
         end
         send_item(b);
      end
   endtask

   task automatic noise_item();
      cmd_type cmd;
      cmd = cmd_type'($urandom_range(3, 0));
      if ((cmd == CMD_ACCUM || cmd == CMD_BLEND) && loaded_list.size() != 0) begin
         send_item(make_cmd(cmd, loaded_list[$urandom_range(loaded_list.size() - 1, 0)]));
      end else if (cmd == CMD_NONE) begin
         send_item(make_cmd(CMD_NONE, $urandom_range(VERTICES - 1, 0)));
      end else begin
         send_item(make_cmd(CMD_LOAD, $urandom_range(VERTICES - 1, 0)));
      end
   endtask

   initial begin
      int unsigned         pick;
      logic [LIP_BITS-1:0] limit;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_LOAD;
      req_if.vertex_index = '0;
      req_if.in_x = '0;
      req_if.in_y = '0;
      req_if.in_z = '0;
      req_if.cur_x = '0;
      req_if.cur_y = '0;
      req_if.cur_z = '0;
      req_if.in_lip_area = 1'b0;
      req_if.lip_area_known = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: limit = '0;
            1: limit = '1;
            3: limit = LIP_BITS'($urandom_range(1023, 0));
            default: limit = LIP_BITS'($urandom);
         endcase
         write_lip_limit(limit);
         if (phase == 0) begin
            directed_items();
         end
         if (phase == 0 || phase == 3) begin
            saturate_vertex($urandom_range(VERTICES - 1, 0));
         end
         while (sent_items < (phase + 1) * ITEMS_PER_PHASE) begin
            pick = $urandom_range(99, 0);
            if (pick < 2) begin
               drain();
            end else if (pick < 72) begin
               mesh_sequence();
            end else begin
               noise_item();
            end
         end
      end
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && blends_outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mpvb_pkg.sv
rtl/mpvb_req_if.sv
rtl/mpvb_rsp_if.sv
rtl/mpvb_ram.sv
rtl/morph_priority_vertex_blender.sv
tb/morph_priority_vertex_blender_checker.sv
tb/morph_priority_vertex_blender_tb.sv
